### design/cfir_pkg.sv
// Shared types and constants of the causal FIR filter.
// No dependencies; every other file of the block refers to this package.
package cfir_pkg;

   localparam int VALUE_W       = 16;
   localparam int PROD_W        = 32;
   localparam int ACC_W         = 40;
   localparam int TAP_INDEX_W   = 4;
   localparam int TAP_COUNT_W   = 5;
   localparam int PADDR_W       = 3;
   localparam int PDATA_W       = 32;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 5'd16;

   // Register word index, taken from paddr[2].
   localparam logic REG_TAP_COUNT = 1'b0;

   // Item kinds on the request channel.
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   // Control that travels with each operand pair into the multiply-accumulate unit.
   typedef struct packed {
      logic vld;
      logic first;
      logic last_tap;
   } mac_ctrl_type;

   typedef struct packed {
      logic                     done;
      logic signed [ACC_W-1:0]  acc;
   } mac_out_type;

endpackage

### design/cfir_req_if.sv
// Request channel of the causal FIR filter: tap loads and samples.
// Depends on cfir_pkg for field widths.
interface cfir_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic [cfir_pkg::TAP_INDEX_W-1:0]     tap_index;
   logic signed [cfir_pkg::VALUE_W-1:0]  value;
   logic                                 last;

   modport source (output valid, action, tap_index, value, last, input ready);
   modport sink   (input valid, action, tap_index, value, last, output ready);
endinterface

### design/cfir_rsp_if.sv
// Response channel of the causal FIR filter: one filtered output per sample.
// Depends on cfir_pkg for field widths.
interface cfir_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cfir_pkg::ACC_W-1:0]  filtered;
   logic                               frame_end;

   modport source (output valid, filtered, frame_end, input ready);
   modport sink   (input valid, filtered, frame_end, output ready);
endinterface

### design/cfir_mac.sv
// Shared multiply-accumulate unit of the causal FIR filter.
// Depends on cfir_pkg for the control and result structs.
module cfir_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfir_pkg::mac_ctrl_type               ctrl,
   input  logic signed [cfir_pkg::VALUE_W-1:0]  a,
   input  logic signed [cfir_pkg::VALUE_W-1:0]  b,
   output cfir_pkg::mac_out_type                result
);

   cfir_pkg::mac_ctrl_type                 p_ctrl_ff;
   logic signed [cfir_pkg::PROD_W-1:0]     prod_ff;
   logic signed [cfir_pkg::ACC_W-1:0]      acc_ff;
   logic signed [cfir_pkg::ACC_W-1:0]      acc_in;
   logic                                   done_ff;

   // The first product of an item starts a fresh sum.
   always_comb begin
      acc_in = (p_ctrl_ff.first ? '0 : acc_ff)
               + {{(cfir_pkg::ACC_W - cfir_pkg::PROD_W){prod_ff[cfir_pkg::PROD_W-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctrl_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         p_ctrl_ff <= ctrl;
         done_ff   <= p_ctrl_ff.vld && p_ctrl_ff.last_tap;
      end
      prod_ff <= a * b;
      if (p_ctrl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign result.done = done_ff;
   assign result.acc  = acc_ff;

endmodule

### design/causal_fir_filter.sv
// Causal direct-form FIR filter over framed Q1.15 samples.
// Depends on cfir_pkg, cfir_req_if, cfir_rsp_if and cfir_mac.

// A load transfer (action 0) writes one Q1.15 coefficient into the tap store and
// produces no response; a load to a tap index at or beyond MAX_TAPS
// is dropped. A sample transfer (action 1) produces one response: the exact Q10.30
// sum over taps 0 to n-1 of coefficient k times the sample k positions earlier in the
// current frame, where n is tap_count clamped to the range 1 to MAX_TAPS, and samples
// from before the frame start count as zero. After a sample transfer the request side
// stays not ready until the sequencer returns to IDLE, so no new sample is taken before
// the last one is through: one shared multiplier and accumulator handles one tap per
// cycle in RUN, then the operand-fetch stage, the registered product, the accumulator
// and the done flag follow, and FLUSH loads the output register. The response becomes
// valid when FLUSH finds the output register free; otherwise the sequencer waits
// until it is. A finished response waits in the output register, and the next transfer
// is taken meanwhile. The sample history is a circular buffer with a fill count, so
// the end of a frame (a sample marked last) empties it at once without a clearing
// pass. The coefficient store has one valid bit per tap, so after reset every tap
// reads as zero until it is loaded. tap_count lives at byte address 0 of the
// APB-style port and resets to 16; it must only be written while the filter is idle.
module causal_fir_filter #(
   parameter int MAX_TAPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   cfir_req_if.sink                          req_ch,
   cfir_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cfir_pkg::PADDR_W-1:0]      paddr,
   input  logic [cfir_pkg::PDATA_W-1:0]      pwdata,
   output logic [cfir_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready
);

   // Tap counter width, history depth and the widths that follow from them.
   localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int HIST_DEPTH = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
   localparam int HIST_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

   typedef enum logic [1:0] {IDLE, RUN, DRAIN, FLUSH} state_type;

   state_type                               state_ff;

   logic [cfir_pkg::TAP_COUNT_W-1:0]        tap_count_ff;

   // Coefficient store and its valid bits.
   logic signed [cfir_pkg::VALUE_W-1:0]     coef_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]                     coef_vld_ff;
   logic signed [cfir_pkg::VALUE_W-1:0]     coef_rd_ff;
   logic                                    coef_vld_rd_ff;

   // Sample history: circular buffer, newest entry just below the write pointer.
   logic signed [cfir_pkg::VALUE_W-1:0]     hist_mem [HIST_DEPTH];
   logic signed [cfir_pkg::VALUE_W-1:0]     hist_rd_ff;
   logic [HIST_W-1:0]                       wp_ff;
   logic [HIST_W-1:0]                       rp_ff;
   logic [FILL_W-1:0]                       fill_ff;

   // Item in progress.
   logic signed [cfir_pkg::VALUE_W-1:0]     sample_ff;
   logic                                    last_ff;
   logic [TAP_W-1:0]                        k_ff;
   logic [TAP_W-1:0]                        last_k_ff;
   logic [TAP_W-1:0]                        last_k_in;

   // Operand-fetch stage that pairs with the registered memory reads.
   cfir_pkg::mac_ctrl_type                  s1_ctrl_ff;
   logic                                    s1_tap0_ff;
   logic                                    s1_hist_ok_ff;
   logic signed [cfir_pkg::VALUE_W-1:0]     mac_a;
   logic signed [cfir_pkg::VALUE_W-1:0]     mac_b;
   cfir_pkg::mac_out_type                   mac_out;

   // Response register.
   logic                                    rsp_valid_ff;
   logic signed [cfir_pkg::ACC_W-1:0]       rsp_filtered_ff;
   logic                                    rsp_frame_end_ff;

   logic                                    req_take;
   logic                                    coef_we;
   logic [TAP_W-1:0]                        coef_waddr;
   logic                                    hist_we;
   logic                                    out_free;
   logic                                    csr_write;

   // Configuration port. Writes complete in the access phase; pready never drops.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == cfir_pkg::REG_TAP_COUNT)
                      ? cfir_pkg::PDATA_W'(tap_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= cfir_pkg::TAP_COUNT_RESET;
      end else if (csr_write && paddr[2] == cfir_pkg::REG_TAP_COUNT) begin
         tap_count_ff <= pwdata[cfir_pkg::TAP_COUNT_W-1:0];
      end
   end

   // Index of the final tap: tap_count clamped to 1..MAX_TAPS, minus one.
   always_comb begin
      if (tap_count_ff == '0) begin
         last_k_in = '0;
      end else if (int'(tap_count_ff) >= MAX_TAPS) begin
         last_k_in = TAP_W'(MAX_TAPS - 1);
      end else begin
         last_k_in = TAP_W'(tap_count_ff - 1'b1);
      end
   end

   // The request side is open only between items.
   assign req_ch.ready = (state_ff == IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign coef_we    = req_take && (req_ch.action == cfir_pkg::ACTION_LOAD)
                       && (int'(req_ch.tap_index) < MAX_TAPS);
   assign coef_waddr = TAP_W'(req_ch.tap_index);

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_ch.value;
      end
      coef_rd_ff <= coef_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_we) begin
         coef_vld_ff[coef_waddr] <= 1'b1;
      end
      coef_vld_rd_ff <= coef_vld_ff[k_ff];
   end

   // The response register frees up in the cycle its transfer completes.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // A finished sample enters the history unless it closes the frame.
   assign hist_we = (state_ff == FLUSH) && out_free && !last_ff;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= sample_ff;
      end
      hist_rd_ff <= hist_mem[rp_ff];
   end

   // Sequencer: one tap per cycle in RUN, then wait for the pipeline to empty and
   // for the response register to be free.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         s1_ctrl_ff   <= '0;
      end else begin
         // A new response loads in FLUSH; otherwise a completed transfer empties it.
         if (state_ff == FLUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         s1_ctrl_ff.vld <= (state_ff == RUN);

         unique case (state_ff)
            IDLE: begin
               if (req_take && req_ch.action == cfir_pkg::ACTION_SAMPLE) begin
                  sample_ff <= req_ch.value;
                  last_ff   <= req_ch.last;
                  last_k_ff <= last_k_in;
                  k_ff      <= '0;
                  rp_ff     <= (wp_ff == '0) ? HIST_W'(HIST_DEPTH - 1) : wp_ff - 1'b1;
                  state_ff  <= RUN;
               end
            end
            RUN: begin
               s1_ctrl_ff.first    <= (k_ff == '0);
               s1_ctrl_ff.last_tap <= (k_ff == last_k_ff);
               s1_tap0_ff          <= (k_ff == '0);
               s1_hist_ok_ff       <= (int'(k_ff) <= int'(fill_ff));
               // Tap 0 uses the present sample, so the history walk starts at tap 1.
               if (k_ff != '0) begin
                  rp_ff <= (rp_ff == '0) ? HIST_W'(HIST_DEPTH - 1) : rp_ff - 1'b1;
               end
               if (k_ff == last_k_ff) begin
                  state_ff <= DRAIN;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            DRAIN: begin
               if (mac_out.done) begin
                  state_ff <= FLUSH;
               end
            end
            FLUSH: begin
               if (out_free) begin
                  rsp_filtered_ff  <= mac_out.acc;
                  rsp_frame_end_ff <= last_ff;
                  if (last_ff) begin
                     fill_ff <= '0;
                  end else begin
                     wp_ff <= (wp_ff == HIST_W'(HIST_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                     if (fill_ff != FILL_W'(HIST_DEPTH)) begin
                        fill_ff <= fill_ff + 1'b1;
                     end
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // Unloaded taps and history positions before the frame start read as zero.
   assign mac_a = coef_vld_rd_ff ? coef_rd_ff : '0;
   assign mac_b = s1_tap0_ff ? sample_ff : (s1_hist_ok_ff ? hist_rd_ff : '0);

   cfir_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (s1_ctrl_ff),
      .a      (mac_a),
      .b      (mac_b),
      .result (mac_out)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.filtered  = rsp_filtered_ff;
   assign rsp_ch.frame_end = rsp_frame_end_ff;

endmodule
